// ===== sv/nmde_pkg.sv =====
// Shared types and constants for the max-difference 3x3 edge filter.
// Used by the top level, nmde_window and nmde_out_fifo; depends on nothing.
package nmde_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;
    localparam int WIN_N = 9;

    // Output queue: deep enough to cover the read stage plus one word in flight
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             present;
        logic [PIX_W-1:0] value;
    } pix_t;

    localparam pix_t PIX_ABSENT = '0;

    // 3x3 neighbourhood, oldest row first, entry 4 is the centre
    typedef struct packed {
        pix_t [WIN_N-1:0] nb;
        logic             left_ok;
        logic             right_ok;
    } win_t;

endpackage

// ===== sv/neighbourhood_max_diff_edge_filter.sv =====
// Top level of the max-difference 3x3 edge filter.
// Depends on nmde_pkg, nmde_ram, nmde_window and nmde_out_fifo.
//
// Takes one pixel (or drain tick) per clock in raster order when not stalled
// and answers, for each real pixel, the largest absolute difference to its
// existing 3x3 neighbours. The answer for a pixel comes out image_width+1
// words after it, then passes the line-store read and the result stage; a
// result queue of four words keeps the input running while the output
// stalls. The line store is a circular RAM with one write and two reads per
// clock (the rows one and two above); a fill count stands in for clearing it,
// so there is no clearing pass after reset. After every write of image_width
// the input stalls while the line-store taps are reloaded for the new width.
// Send image_width+1 drain ticks after an image to flush its last row.
module neighbourhood_max_diff_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nmde_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [nmde_pkg::PIX_W-1:0]    pixel_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nmde_pkg::PIX_W-1:0]    edge_value
);

    import nmde_pkg::*;

    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW        = $clog2(2 * MAX_WIDTH + 3);
    localparam int RAM_DEPTH = 1 << AW;
    localparam logic [AW-1:0] FILL_CAP = AW'(2 * MAX_WIDTH + 2);
    localparam int PW        = $bits(pix_t);

    // configuration and reload
    logic [WW-1:0] ew_reg;
    logic [WW-1:0] ew_next;
    logic [1:0]    reload_reg;
    logic          reload_busy;

    // line store addressing
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] w_a;
    logic [AW-1:0] dist_a;
    logic [AW-1:0] dist_b;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [PW-1:0] rd_a;
    logic [PW-1:0] rd_b;
    logic [1:0]    off;

    // input side
    logic          accept;
    logic          issue;
    pix_t          new_pix;
    pix_t          h1_reg;
    pix_t          h2_reg;

    // read stage
    logic          s1_shift_reg;
    logic          s1_item_reg;
    pix_t          s1_c0_reg;
    pix_t          s1_h1_reg;
    pix_t          s1_h2_reg;
    logic          s1_va_reg;
    logic          s1_vb_reg;

    // taps of the rows above, one and two positions older than the reads
    pix_t          a1_reg;
    pix_t          a2_reg;
    pix_t          b1_reg;
    pix_t          b2_reg;
    pix_t          na;
    pix_t          nb_b;

    // column tracking and result
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [WW-1:0] col_eff;
    logic [WW-1:0] col_inc;
    logic          wide;
    win_t          win;
    logic [PIX_W-1:0] win_edge;
    logic          centre_present;
    logic          push;

    logic [OUTQ_CW-1:0] q_count;
    logic [OUTQ_CW:0]   q_load;

    // ---------------- configuration ----------------
    always_comb
    begin
        if (cfg_wdata == '0)
            ew_next = WW'(1);
        else if (32'(cfg_wdata) > 32'(MAX_WIDTH))
            ew_next = WW'(MAX_WIDTH);
        else
            ew_next = WW'(cfg_wdata);
    end

    assign reload_busy = (reload_reg != 2'd0);

    // ---------------- input and line store ----------------
    assign q_load   = {1'b0, q_count} + (OUTQ_CW + 1)'(s1_item_reg);
    assign in_stall = reload_busy || (q_load >= (OUTQ_CW + 1)'(OUTQ_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign issue    = accept || reload_busy;

    assign new_pix.present = (op == OP_PIXEL);
    assign new_pix.value   = pixel_value;

    // reload reads fetch the taps two, then one, positions older
    assign off     = reload_busy ? reload_reg : 2'd0;
    assign w_a     = AW'(ew_reg);
    assign dist_a  = w_a + AW'(off);
    assign dist_b  = (w_a << 1) + AW'(off);
    assign raddr_a = wp_reg - dist_a;
    assign raddr_b = wp_reg - dist_b;

    nmde_ram #(
        .WIDTH (PW),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (wp_reg),
        .wdata   (new_pix),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg       <= WW'(1);
            reload_reg   <= 2'd0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            h1_reg       <= PIX_ABSENT;
            h2_reg       <= PIX_ABSENT;
            s1_shift_reg <= 1'b0;
            s1_item_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ew_reg     <= ew_next;
                reload_reg <= 2'd2;
            end
            else if (reload_busy)
            begin
                reload_reg <= reload_reg - 2'd1;
            end
            if (accept)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (fill_reg != FILL_CAP)
                    fill_reg <= fill_reg + 1'b1;
                h1_reg <= new_pix;
                h2_reg <= h1_reg;
            end
            s1_shift_reg <= issue;
            s1_item_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_c0_reg <= new_pix;
            s1_h1_reg <= h1_reg;
            s1_h2_reg <= h2_reg;
            // entries older than the fill count were never written
            s1_va_reg <= (dist_a <= fill_reg);
            s1_vb_reg <= (dist_b <= fill_reg);
        end
    end

    // ---------------- window and result ----------------
    assign na   = s1_va_reg ? pix_t'(rd_a) : PIX_ABSENT;
    assign nb_b = s1_vb_reg ? pix_t'(rd_b) : PIX_ABSENT;

    always_comb
    begin
        wide    = (ew_reg > WW'(1));
        col_eff = (WW'(col_reg) >= ew_reg) ? '0 : WW'(col_reg);
        col_inc = col_eff + 1'b1;
        col_next = (col_inc >= ew_reg) ? '0 : CW'(col_inc);

        win.nb[0]    = b2_reg;
        win.nb[1]    = b1_reg;
        win.nb[2]    = nb_b;
        win.nb[3]    = a2_reg;
        win.nb[4]    = a1_reg;
        win.nb[5]    = na;
        win.nb[6]    = s1_h2_reg;
        win.nb[7]    = s1_h1_reg;
        win.nb[8]    = s1_c0_reg;
        win.left_ok  = wide && (col_eff != '0);
        win.right_ok = wide && (col_eff != (ew_reg - 1'b1));
    end

    nmde_window u_window (
        .win            (win),
        .edge_value     (win_edge),
        .centre_present (centre_present)
    );

    assign push = s1_item_reg && centre_present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg  <= PIX_ABSENT;
            a2_reg  <= PIX_ABSENT;
            b1_reg  <= PIX_ABSENT;
            b2_reg  <= PIX_ABSENT;
            col_reg <= '0;
        end
        else
        begin
            // advance the row taps once per read, item or reload
            if (s1_shift_reg)
            begin
                a1_reg <= na;
                a2_reg <= a1_reg;
                b1_reg <= nb_b;
                b2_reg <= b1_reg;
            end
            if (push)
                col_reg <= col_next;
        end
    end

    nmde_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (win_edge),
        .count (q_count),
        .valid (out_valid),
        .stall (out_stall),
        .rdata (edge_value)
    );

    // ---------------- assertions ----------------
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < OUTQ_CW'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_push_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(accept))
        else $error("result without an accepted word one clock earlier");

    a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (fill_reg != FILL_CAP)) |=> (fill_reg == AW'($past(fill_reg) + 1'b1)))
        else $error("fill count did not follow accepted word");

endmodule

// ===== sv/nmde_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds the pixel line store.
module nmde_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    output logic [WIDTH-1:0]           rdata_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [WIDTH-1:0]           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== sv/nmde_window.sv =====
// Max absolute difference of the centre to the present 3x3 neighbours.
// Depends on nmde_pkg for the window and pixel types.
module nmde_window (
    input  nmde_pkg::win_t                win,
    output logic [nmde_pkg::PIX_W-1:0]    edge_value,
    output logic                          centre_present
);

    import nmde_pkg::*;

    logic [PIX_W-1:0] diff [WIN_N];
    logic [PIX_W-1:0] lvl1 [4];
    logic [PIX_W-1:0] lvl2 [2];

    function automatic logic [PIX_W-1:0] pick_max(input logic [PIX_W-1:0] x,
                                                  input logic [PIX_W-1:0] y);
        return (x > y) ? x : y;
    endfunction

    always_comb
    begin
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic             use_nb;

        b = win.nb[4].value;
        for (int i = 0; i < WIN_N; i++)
        begin
            a = win.nb[i].value;
            // left column needs a left neighbor, right column a right one
            if (i == 4)
                use_nb = 1'b0;
            else if ((i % 3) == 0)
                use_nb = win.left_ok;
            else if ((i % 3) == 2)
                use_nb = win.right_ok;
            else
                use_nb = 1'b1;
            // absent or unused neighbors count as zero
            if (use_nb && win.nb[i].present)
                diff[i] = (a >= b) ? (a - b) : (b - a);
            else
                diff[i] = '0;
        end
    end

    // balanced max over the eight neighbors
    assign lvl1[0] = pick_max(diff[0], diff[1]);
    assign lvl1[1] = pick_max(diff[2], diff[3]);
    assign lvl1[2] = pick_max(diff[5], diff[6]);
    assign lvl1[3] = pick_max(diff[7], diff[8]);
    assign lvl2[0] = pick_max(lvl1[0], lvl1[1]);
    assign lvl2[1] = pick_max(lvl1[2], lvl1[3]);

    assign edge_value     = pick_max(lvl2[0], lvl2[1]);
    assign centre_present = win.nb[4].present;

endmodule

// ===== sv/nmde_out_fifo.sv =====
// Small result queue between the filter pipeline and the output channel.
// Depends on nmde_pkg for its depth and word width.
module nmde_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [nmde_pkg::PIX_W-1:0]    wdata,
    output logic [nmde_pkg::OUTQ_CW-1:0]  count,
    output logic                          valid,
    input  logic                          stall,
    output logic [nmde_pkg::PIX_W-1:0]    rdata
);

    import nmde_pkg::*;

    logic [PIX_W-1:0]   mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_CW-1:0] cnt_reg;
    logic [OUTQ_CW-1:0] cnt_next;
    logic               pop;

    assign valid = (cnt_reg != '0);
    assign pop   = valid && !stall;
    assign rdata = mem_reg[rd_ptr_reg];
    assign count = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the max-difference 3x3 edge filter: directed and random pixel streams
// over many row widths, each result word checked against a predictor built in here.
// Depends on nmde_pkg and neighbourhood_max_diff_edge_filter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nmde_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int HIST_N     = 2 * MAX_W + 3;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE     = 8;
    localparam int RANDOM_N   = 650;

    class max_diff_scoreboard;
        pix_t             history[HIST_N];
        int               newest;
        logic [CFG_W-1:0] width_reg;
        int               column;
        logic [PIX_W-1:0] expected_edges[$];
        int               errors;
        int               checked;

        function new();
            foreach (history[i])
                history[i] = PIX_ABSENT;
            newest    = 0;
            width_reg = CFG_W'(1);
            column    = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function int row_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_W)
                return MAX_W;
            return int'(width_reg);
        endfunction

        function pix_t back(int k);
            return history[(newest + HIST_N - k) % HIST_N];
        endfunction

        function int widen(int best, pix_t nb, pix_t centre);
            int a;
            int b;
            int d;
            if (!nb.present)
                return best;
            a = int'(nb.value);
            b = int'(centre.value);
            d = (a > b) ? a - b : b - a;
            return (d > best) ? d : best;
        endfunction

        // note one accepted input word and queue the result it releases, if any
        function void take_word(logic o, logic [PIX_W-1:0] p);
            int   w;
            int   col;
            int   best;
            bit   left_ok;
            bit   right_ok;
            pix_t nb[WIN_N];
            newest = (newest + 1) % HIST_N;
            history[newest] = (o == OP_PIXEL) ? pix_t'{present: 1'b1, value: p} : PIX_ABSENT;
            w = row_width();
            nb[0] = back(2 * w + 2);
            nb[1] = back(2 * w + 1);
            nb[2] = back(2 * w);
            nb[3] = back(w + 2);
            nb[4] = back(w + 1);
            nb[5] = back(w);
            nb[6] = back(2);
            nb[7] = back(1);
            nb[8] = back(0);
            if (!nb[4].present)
                return;
            col = (column >= w) ? 0 : column;
            left_ok  = (w >= 2) && (col != 0);
            right_ok = (w >= 2) && (col != w - 1);
            best = widen(0, nb[1], nb[4]);
            best = widen(best, nb[7], nb[4]);
            if (left_ok)
            begin
                best = widen(best, nb[0], nb[4]);
                best = widen(best, nb[3], nb[4]);
                best = widen(best, nb[6], nb[4]);
            end
            if (right_ok)
            begin
                best = widen(best, nb[2], nb[4]);
                best = widen(best, nb[5], nb[4]);
                best = widen(best, nb[8], nb[4]);
            end
            column = (col + 1 >= w) ? 0 : col + 1;
            expected_edges.push_back(PIX_W'(best));
        endfunction

        function void check_edge(logic [PIX_W-1:0] actual);
            logic [PIX_W-1:0] want;
            if (expected_edges.size() == 0)
            begin
                $error("edge_value: expected no word, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_edges.pop_front();
            checked++;
            if (actual !== want)
            begin
                $error("edge_value: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    logic             op;
    logic [PIX_W-1:0] pixel_value;
    logic             out_valid;
    logic             out_stall;
    logic [PIX_W-1:0] edge_value;

    max_diff_scoreboard sb = new();

    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;
    int rx_hold_req    = 0;
    int words_sent     = 0;
    int widths_written = 0;

    neighbourhood_max_diff_edge_filter #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .pixel_value(pixel_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_value (edge_value)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    // result side: random stall after each word, plus an occasional long hold-off
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_edge(edge_value);
                stall_left = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            out_stall <= (stall_left != 0) || (hold_left != 0);
            if (stall_left != 0)
                stall_left--;
            if (hold_left != 0)
                hold_left--;
        end
    end

    task automatic send_word(input logic o, input logic [PIX_W-1:0] p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        pixel_value <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_word(o, p);
        words_sent++;
    endtask

    task automatic send_drain(input int count);
        repeat (count)
            send_word(OP_DRAIN, PIX_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [PIX_W-1:0] next_pixel(input int style, input logic [PIX_W-1:0] prev);
        int v;
        case (style)
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2:
            begin
                v = int'(prev);
                v += $urandom_range(0, 16);
                v -= 8;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            default: v = $urandom_range(0, 255);
        endcase
        return PIX_W'(v);
    endfunction

    task automatic send_pixels(input int count, input int style, input bit noisy);
        logic [PIX_W-1:0] v;
        v = PIX_W'($urandom_range(0, 255));
        for (int i = 0; i < count; i++)
        begin
            // drop in a stray absent pixel now and then
            if (noisy && $urandom_range(0, 24) == 0)
                send_word(OP_DRAIN, PIX_W'($urandom_range(0, 255)));
            v = next_pixel(style, v);
            send_word(OP_PIXEL, v);
        end
    endtask

    // hold the input and let every outstanding result come home
    task automatic wait_for_edges();
        in_valid <= 1'b0;
        while (sb.expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        wait_for_edges();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.width_reg = w;
        widths_written++;
    endtask

    initial
    begin : stimulus
        int random_start;
        int phase;
        int phase_w;
        int eff;
        int rows;
        int extra;
        int pad;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        op          <= OP_PIXEL;
        pixel_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width of one: only the pixels above and below count
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd255);
        send_word(OP_PIXEL, 8'd128);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_DRAIN, 8'd255);
        send_word(OP_DRAIN, 8'd0);

        // 3x3 checkerboard of extremes, then flush the last row
        write_width(11'd3);
        for (int i = 0; i < 9; i++)
            send_word(OP_PIXEL, (i % 2 == 0) ? 8'd255 : 8'd0);
        send_drain(4);

        random_start = words_sent;
        phase = 0;
        while (words_sent - random_start < RANDOM_N)
        begin
            tx_idle = ($urandom_range(0, 9) < 7);
            rx_idle = ($urandom_range(0, 9) < 7);
            case ($urandom_range(0, 9))
                0: phase_w = 0;
                1: phase_w = $urandom_range(9, 40);
                default: phase_w = $urandom_range(1, 8);
            endcase
            rows = $urandom_range(1, 5);
            if (phase == 2)
            begin
                // stream hard into a long output hold-off so the block backs up
                phase_w = 6;
                rows    = 8;
                tx_idle = 1'b0;
            end
            write_width(CFG_W'(phase_w));
            eff = (phase_w == 0) ? 1 : phase_w;
            if (phase == 2)
                rx_hold_req = 300;
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : 0;
            send_pixels(rows * eff + extra, $urandom_range(0, 2), 1'b1);
            // leave some images undrained so the next width sees the old history
            if ($urandom_range(0, 4) != 0)
                send_drain(eff + 1);
            phase++;
        end

        // widest rows: reuse the long history kept so far instead of a whole image
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_width(11'h7FF);
        pad = (words_sent < 1000) ? 1000 - words_sent : 0;
        send_pixels(pad + 60, 0, 1'b0);
        write_width(11'(MAX_W));
        send_pixels(40, 1, 1'b0);

        wait_for_edges();
        $display("run covered %0d input words and %0d checked edge results", words_sent,
                 sb.checked);
        $display("%0d row widths written: random small ones, then the widest and an oversize one",
                 widths_written);
        if (sb.errors == 0 && sb.expected_edges.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
